// ----- rtl/fsws_pkg.sv -----
// Shared types, codes and widths of the fragment stop-and-wait sender.
package fsws_pkg;

  localparam int IDX_W = 16;
  localparam int CNT_W = 16;
  localparam int ATT_W = 9;
  localparam int DEV_W = 64;
  localparam int CAP_W = 32;
  localparam int CFG_W = 16;
  localparam int NUM_STATS = 7;

  // operations
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_STEP  = 2'd1;
  localparam logic [1:0] OP_ABORT = 2'd2;

  // transfer phases
  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_BUILD    = 4'd1;
  localparam logic [3:0] PH_START_TX = 4'd2;
  localparam logic [3:0] PH_WAIT_TX  = 4'd3;
  localparam logic [3:0] PH_WAIT_ACK = 4'd4;
  localparam logic [3:0] PH_ADVANCE  = 4'd5;
  localparam logic [3:0] PH_COMPLETE = 4'd6;
  localparam logic [3:0] PH_ABORTED  = 4'd7;
  localparam logic [3:0] PH_ERROR    = 4'd8;

  // radio commands
  localparam logic [2:0] CMD_NONE    = 3'd0;
  localparam logic [2:0] CMD_BUILD   = 3'd1;
  localparam logic [2:0] CMD_SEND    = 3'd2;
  localparam logic [2:0] CMD_RX      = 3'd3;
  localparam logic [2:0] CMD_STANDBY = 3'd4;

  // result status
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_IN_FLIGHT = 2'd1;
  localparam logic [1:0] ST_ERROR     = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_ACK_EN      = 2'd0;
  localparam logic [1:0] CFG_MAX_RETRIES = 2'd1;
  localparam logic [1:0] CFG_SKIP_PERIOD = 2'd2;

  // statistics counter slots
  localparam int CI_RETRIES   = 0;
  localparam int CI_TIMEOUTS  = 1;
  localparam int CI_RADIO_ERR = 2;
  localparam int CI_TX_DONE   = 3;
  localparam int CI_ACKS      = 4;
  localparam int CI_FAILED    = 5;
  localparam int CI_TX_START  = 6;

  typedef struct packed {
    logic [1:0]       operation;
    logic [IDX_W-1:0] frag_total;
    logic [DEV_W-1:0] sender_dev;
    logic [CAP_W-1:0] capture_tag;
    logic             radio_busy;
    logic             step_ok;
    logic             rx_start_ok;
    logic             ack_valid;
    logic [DEV_W-1:0] ack_device;
    logic [CAP_W-1:0] ack_capture;
    logic [IDX_W-1:0] ack_index;
    logic [7:0]       ack_code;
  } req_t;

  typedef struct packed {
    logic [3:0]       phase;
    logic [2:0]       command;
    logic [IDX_W-1:0] current_index;
    logic [ATT_W-1:0] attempt;
    logic [1:0]       status;
    logic [CNT_W-1:0] retries_total;
    logic [CNT_W-1:0] ack_timeouts_total;
    logic [CNT_W-1:0] radio_errors_total;
    logic [CNT_W-1:0] tx_done_total;
    logic [CNT_W-1:0] acks_total;
    logic [CNT_W-1:0] failed_index;
    logic [CNT_W-1:0] tx_started_total;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic                 start;
    logic                 att_clr;
    logic                 att_inc;
    logic                 idx_inc;
    logic                 fail_cap;
    logic [NUM_STATS-1:0] bump;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic ack_en;
    logic att_le_max;
    logic att_inc_le_max;
    logic skip_hit;
    logic ack_match;
    logic last_frag;
    logic mod_busy;
  } dp_sts_t;

endpackage

// ----- rtl/fsws_ifs.sv -----
// Request and result channel interfaces of the fragment sender.
interface fsws_req_if;
  logic               valid;
  logic               ready;
  fsws_pkg::req_t     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface fsws_rsp_if;
  logic               valid;
  logic               ready;
  fsws_pkg::rsp_t     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/fsws_rem.sv -----
// Serial restoring remainder unit, one quotient bit per cycle.
module fsws_rem (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [fsws_pkg::IDX_W-1:0] dividend_i,
  input  logic [fsws_pkg::IDX_W-1:0] divisor_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [fsws_pkg::IDX_W-1:0] rem_o
);
  import fsws_pkg::*;

  localparam int CW = $clog2(IDX_W);

  logic          busy_q, busy_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] dvd_q, dvd_d;
  logic [IDX_W-1:0] div_q, div_d;
  logic [IDX_W-1:0] rem_q, rem_d;
  logic [IDX_W:0]   part;
  logic [IDX_W:0]   diff;

  assign part = {rem_q, dvd_q[IDX_W-1]};
  assign diff = part - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(IDX_W - 1);
      dvd_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[IDX_W-2:0], 1'b0};
      rem_d = diff[IDX_W] ? part[IDX_W-1:0] : diff[IDX_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  // last iteration: rem_d holds the final remainder
  assign done_o = busy_q && (cnt_q == '0) && !start_i;
  assign rem_o  = rem_d;

endmodule

// ----- rtl/fsws_dp.sv -----
// Datapath: position, identifiers, config, statistics and index-modulo tracker.
module fsws_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  fsws_pkg::req_t             req_i,
  input  fsws_pkg::dp_cmd_t          cmd_i,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [fsws_pkg::CFG_W-1:0] cfg_data_i,
  output fsws_pkg::dp_sts_t          sts_o,
  output logic [fsws_pkg::IDX_W-1:0] index_o,
  output logic [fsws_pkg::ATT_W-1:0] attempt_o,
  output logic [fsws_pkg::CNT_W-1:0] stats_o [fsws_pkg::NUM_STATS]
);
  import fsws_pkg::*;

  logic             ack_en_q;
  logic [7:0]       max_retries_q;
  logic [IDX_W-1:0] skip_q;

  logic [IDX_W-1:0] index_q;
  logic [ATT_W-1:0] attempt_q;
  logic [IDX_W-1:0] count_q;
  logic [DEV_W-1:0] device_q;
  logic [CAP_W-1:0] capture_q;
  logic [CNT_W-1:0] stat_q [NUM_STATS];
  logic [IDX_W-1:0] mod_q;

  logic [IDX_W-1:0] index_inc;
  logic [ATT_W-1:0] attempt_inc;
  logic [IDX_W-1:0] mod_inc;
  logic             rem_start;
  logic             rem_busy;
  logic             rem_done;
  logic [IDX_W-1:0] rem_val;

  assign index_inc   = index_q + 1'b1;
  assign attempt_inc = (attempt_q == '1) ? attempt_q : attempt_q + 1'b1;
  assign mod_inc     = (mod_q + 1'b1 == skip_q) ? '0 : mod_q + 1'b1;

  // a new nonzero period invalidates the tracker: recompute index mod period
  assign rem_start = cfg_we_i && (cfg_idx_i == CFG_SKIP_PERIOD) && (cfg_data_i != '0);

  fsws_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (index_q),
    .divisor_i  (cfg_data_i[IDX_W-1:0]),
    .busy_o     (rem_busy),
    .done_o     (rem_done),
    .rem_o      (rem_val)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_en_q      <= 1'b1;
      max_retries_q <= 8'd3;
      skip_q        <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ACK_EN:      ack_en_q      <= cfg_data_i[0];
        CFG_MAX_RETRIES: max_retries_q <= cfg_data_i[7:0];
        CFG_SKIP_PERIOD: skip_q        <= cfg_data_i[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_q   <= '0;
      attempt_q <= '0;
      count_q   <= '0;
      device_q  <= '0;
      capture_q <= '0;
      mod_q     <= '0;
      for (int k = 0; k < NUM_STATS; k++) stat_q[k] <= '0;
    end else begin
      if (cmd_i.start) begin
        index_q   <= '0;
        attempt_q <= '0;
        count_q   <= req_i.frag_total;
        device_q  <= req_i.sender_dev;
        capture_q <= req_i.capture_tag;
        for (int k = 0; k < NUM_STATS; k++) stat_q[k] <= '0;
      end else begin
        if (cmd_i.idx_inc) index_q <= index_inc;
        if (cmd_i.att_clr) attempt_q <= '0;
        else if (cmd_i.att_inc) attempt_q <= attempt_inc;
        for (int k = 0; k < NUM_STATS; k++) begin
          if (cmd_i.bump[k] && stat_q[k] != '1) stat_q[k] <= stat_q[k] + 1'b1;
        end
        if (cmd_i.fail_cap) stat_q[CI_FAILED] <= index_q[CNT_W-1:0];
      end
      if (rem_done) mod_q <= rem_val;
      else if (cmd_i.start) mod_q <= '0;
      else if (cmd_i.idx_inc) mod_q <= mod_inc;
    end
  end

  always_comb begin
    sts_o.ack_en         = ack_en_q;
    sts_o.att_le_max     = attempt_q <= {1'b0, max_retries_q};
    sts_o.att_inc_le_max = attempt_inc <= {1'b0, max_retries_q};
    sts_o.skip_hit       = (skip_q != '0) && (attempt_q == '0) && (mod_q == '0);
    sts_o.ack_match      = req_i.ack_valid && (req_i.ack_device == device_q) &&
                           (req_i.ack_capture == capture_q) &&
                           (req_i.ack_index == index_q) && (req_i.ack_code == 8'd0);
    sts_o.last_frag      = index_inc >= count_q;
    sts_o.mod_busy       = rem_busy;
  end

  assign index_o   = index_q;
  assign attempt_o = attempt_q;
  assign stats_o   = stat_q;

  a_mod_below_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!rem_busy && skip_q != '0) |-> (mod_q < skip_q))
    else $error("index modulo tracker out of range");

  a_start_clears_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.start && !rem_done) |=> (index_q == '0 && attempt_q == '0 && mod_q == '0))
    else $error("start did not clear position");

endmodule

// ----- rtl/fsws_ctrl.sv -----
// Controller: transfer phase machine, handshake and result command/status.
module fsws_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  fsws_pkg::req_t     req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  fsws_pkg::dp_sts_t  sts_i,
  output fsws_pkg::dp_cmd_t  cmd_o,
  output logic [3:0]         phase_o,
  output logic [2:0]         command_o,
  output logic [1:0]         status_o
);
  import fsws_pkg::*;

  logic [3:0] phase_q, phase_d;
  logic [2:0] command_q, command_d;
  logic [1:0] status_q, status_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       active;
  logic       retry_req;
  logic       retry_le;
  logic [2:0] finish_cmd;
  dp_cmd_t    cmd;

  assign in_ready_o = !sts_i.mod_busy && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign active     = (phase_q == PH_BUILD) || (phase_q == PH_START_TX) ||
                      (phase_q == PH_WAIT_TX) || (phase_q == PH_WAIT_ACK) ||
                      (phase_q == PH_ADVANCE);
  assign finish_cmd = req_i.radio_busy ? CMD_STANDBY : CMD_NONE;

  always_comb begin
    phase_d   = phase_q;
    command_d = CMD_NONE;
    status_d  = ST_OK;
    cmd       = '0;
    retry_req = 1'b0;
    retry_le  = 1'b0;

    unique case (req_i.operation)
      OP_START: begin
        if (active) begin
          status_d = ST_IN_FLIGHT;
        end else begin
          cmd.start = 1'b1;
          phase_d   = PH_BUILD;
        end
      end
      OP_ABORT: begin
        if (active) begin
          phase_d   = PH_ABORTED;
          command_d = finish_cmd;
        end
      end
      OP_STEP: begin
        unique case (phase_q)
          PH_BUILD: begin
            command_d = CMD_BUILD;
            if (!req_i.step_ok) begin
              phase_d   = PH_ERROR;
              command_d = finish_cmd;
              status_d  = ST_ERROR;
            end else begin
              cmd.att_clr = 1'b1;
              phase_d     = PH_START_TX;
            end
          end
          PH_START_TX: begin
            cmd.att_inc              = 1'b1;
            cmd.bump[CI_TX_START]    = 1'b1;
            retry_le                 = sts_i.att_inc_le_max;
            if (sts_i.skip_hit) begin
              // first attempt dropped on purpose: a lost ack if ack_en
              if (sts_i.ack_en) begin
                cmd.bump[CI_TIMEOUTS] = 1'b1;
                retry_req             = 1'b1;
              end else begin
                phase_d = PH_ADVANCE;
              end
            end else begin
              command_d = CMD_SEND;
              if (!req_i.step_ok) begin
                cmd.bump[CI_RADIO_ERR] = 1'b1;
                retry_req              = 1'b1;
              end else begin
                phase_d = PH_WAIT_TX;
              end
            end
          end
          PH_WAIT_TX: begin
            retry_le = sts_i.att_le_max;
            if (!req_i.radio_busy) begin
              if (!req_i.step_ok) begin
                cmd.bump[CI_RADIO_ERR] = 1'b1;
                retry_req              = 1'b1;
              end else begin
                cmd.bump[CI_TX_DONE] = 1'b1;
                if (!sts_i.ack_en) begin
                  phase_d = PH_ADVANCE;
                end else begin
                  command_d = CMD_RX;
                  if (!req_i.rx_start_ok) begin
                    cmd.bump[CI_RADIO_ERR] = 1'b1;
                    retry_req              = 1'b1;
                  end else begin
                    phase_d = PH_WAIT_ACK;
                  end
                end
              end
            end
          end
          PH_WAIT_ACK: begin
            retry_le = sts_i.att_le_max;
            if (!req_i.radio_busy) begin
              if (sts_i.ack_match) begin
                cmd.bump[CI_ACKS] = 1'b1;
                phase_d           = PH_ADVANCE;
              end else begin
                cmd.bump[CI_TIMEOUTS] = 1'b1;
                retry_req             = 1'b1;
              end
            end
          end
          PH_ADVANCE: begin
            cmd.idx_inc = 1'b1;
            if (sts_i.last_frag) begin
              phase_d   = PH_COMPLETE;
              command_d = finish_cmd;
            end else begin
              phase_d = PH_BUILD;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    if (retry_req) begin
      if (retry_le) begin
        cmd.bump[CI_RETRIES] = 1'b1;
        phase_d              = PH_START_TX;
      end else begin
        cmd.fail_cap = 1'b1;
        phase_d      = PH_ABORTED;
        command_d    = finish_cmd;
      end
    end
  end

  assign cmd_o       = accept ? cmd : '0;
  assign out_valid_d = accept ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      command_q   <= CMD_NONE;
      status_q    <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        phase_q   <= phase_d;
        command_q <= command_d;
        status_q  <= status_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign phase_o     = phase_q;
  assign command_o   = command_q;
  assign status_o    = status_q;

  a_result_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(accept))
    else $error("result appeared without an accepted word");

  a_no_accept_in_recompute: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !sts_i.mod_busy)
    else $error("word accepted while modulo tracker recomputes");

  a_start_enters_build: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd.start) |=> (phase_q == PH_BUILD && status_q == ST_OK))
    else $error("start did not enter build phase");

endmodule

// ----- rtl/fragment_stop_and_wait_sender.sv -----
// Each accepted request word (start, service step or abort) yields exactly one result word,
// registered and presented the cycle after acceptance; a new word is taken in the same cycle
// the previous result is taken, so the block sustains one word per cycle unless the result
// waits or a remainder runs. The phase machine and all statistics register with the result.
// A write of a nonzero skip_period starts a serial remainder of the current fragment index
// by the new period, one bit per cycle; while it runs the request channel is held not ready.
// Configuration writes are taken at any time with cfg_we_i and have no read-back.
module fragment_stop_and_wait_sender (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  fsws_req_if.sink                   in_i,
  fsws_rsp_if.source                 out_o,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [fsws_pkg::CFG_W-1:0] cfg_data_i
);
  import fsws_pkg::*;

  dp_cmd_t          dp_cmd;
  dp_sts_t          dp_sts;
  logic [IDX_W-1:0] index;
  logic [ATT_W-1:0] attempt;
  logic [CNT_W-1:0] stats [NUM_STATS];
  logic [3:0]       phase;
  logic [2:0]       command;
  logic [1:0]       status;

  fsws_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .req_i       (in_i.data),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (dp_sts),
    .cmd_o       (dp_cmd),
    .phase_o     (phase),
    .command_o   (command),
    .status_o    (status)
  );

  fsws_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (in_i.data),
    .cmd_i      (dp_cmd),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .sts_o      (dp_sts),
    .index_o    (index),
    .attempt_o  (attempt),
    .stats_o    (stats)
  );

  // position and statistics registers hold the post-step values until the next accept
  always_comb begin
    out_o.data.phase              = phase;
    out_o.data.command            = command;
    out_o.data.current_index      = index;
    out_o.data.attempt            = attempt;
    out_o.data.status             = status;
    out_o.data.retries_total      = stats[CI_RETRIES];
    out_o.data.ack_timeouts_total = stats[CI_TIMEOUTS];
    out_o.data.radio_errors_total = stats[CI_RADIO_ERR];
    out_o.data.tx_done_total      = stats[CI_TX_DONE];
    out_o.data.acks_total         = stats[CI_ACKS];
    out_o.data.failed_index       = stats[CI_FAILED];
    out_o.data.tx_started_total   = stats[CI_TX_START];
  end

endmodule
